FILE: hdl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg: shared constants and types of the masked pattern dedup unit
// Widths, register indexes and the front-to-back work descriptor.
// ----------------------------------------------------------------------------
`default_nettype none
package mpd_pkg;
   localparam int TableDepth      = 1024;
   localparam int MaxPatternBytes = 16;
   localparam int EntryWidth      = $clog2(TableDepth);
   localparam int CountWidth      = $clog2(TableDepth + 1);
   localparam int PosWidth        = $clog2(MaxPatternBytes);
   localparam int LenWidth        = 5;
   localparam int RowWidth        = 8 * MaxPatternBytes;
   localparam int IndexWidth      = 10;
   localparam int QueueDepth      = 2;

   localparam logic [1:0] RegMaskMatch = 2'd0;
   localparam logic [1:0] RegNormalize = 2'd1;
   localparam logic [1:0] RegLength    = 2'd2;

   typedef struct packed {
      logic [RowWidth-1:0] bytes;
      logic [RowWidth-1:0] masks;
      logic [RowWidth-1:0] len_mask;
      logic                mask_match;
   } job_type;
endpackage
`default_nettype wire

FILE: hdl/masked_pattern_dedup_unit.sv
// ----------------------------------------------------------------------------
// masked_pattern_dedup_unit: masked pattern deduplication
// Assembles patterns of masked bytes and looks them up in a store of unique
// patterns, appending those that match nothing while the store has room.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// req_      in         push / full       data_byte, mask_byte
// rsp_      out        empty / pop       pattern_index, is_new, store_full
// csr_      in         valid / ready     index (2 bits), data (5 bits)
//
// A byte request is taken in the cycle it is pushed while the job queue is
// not full; the last byte of a pattern queues a search job. A search reads
// one store entry per cycle in an exact pass and, if mask matching is on, a
// masked pass, over the N entries held (at most 1024), then appends a new
// entry or reports a hit and offers the result. The single read port of the
// store sets the pace of the search. Reset clears the entry count but not
// the store; the store needs no clearing pass. Requests stall only when the
// two-deep job queue is full; the result is held until popped.
// ----------------------------------------------------------------------------
`default_nettype none
module masked_pattern_dedup_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic [7:0]                     req_mask_byte,
   output logic                                empty,
   input  wire logic                           pop,
   output logic [mpd_pkg::IndexWidth-1:0]      rsp_pattern_index,
   output logic                                rsp_is_new,
   output logic                                rsp_store_full,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [1:0]                     csr_index,
   input  wire logic [mpd_pkg::LenWidth-1:0]   csr_data
);
   logic                         mask_match_ff, normalize_ff;
   logic [mpd_pkg::LenWidth-1:0] length_ff;
   logic                         csr_write, restart, accept;
   logic                         job_valid, job_pop, q_empty;
   mpd_pkg::job_type             job_new, job_head;

   // Configuration is always accepted; the user must write it only while the block is idle, which it does not enforce.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign restart   = csr_write && csr_index == mpd_pkg::RegLength;
   assign accept    = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_match_ff <= 1'b0;
         normalize_ff  <= 1'b0;
         length_ff     <= 5'd16;
      end else if (csr_write) begin
         case (csr_index)
            mpd_pkg::RegMaskMatch: mask_match_ff <= csr_data[0];
            mpd_pkg::RegNormalize: normalize_ff  <= csr_data[0];
            mpd_pkg::RegLength:    length_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   mpd_front u_front (
      .clock, .reset,
      .in_valid   (accept),
      .data_byte  (req_data_byte),
      .mask_byte  (req_mask_byte),
      .mask_match (mask_match_ff),
      .normalize  (normalize_ff),
      .length     (length_ff),
      .restart    (restart),
      .job        (job_new),
      .job_valid  (job_valid)
   );

   mpd_queue u_queue (
      .clock, .reset,
      .push     (job_valid),
      .push_job (job_new),
      .full     (full),
      .pop      (job_pop),
      .head     (job_head),
      .empty    (q_empty)
   );

   mpd_back u_back (
      .clock, .reset,
      .job               (job_head),
      .job_empty         (q_empty),
      .job_pop           (job_pop),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_pattern_index (rsp_pattern_index),
      .rsp_is_new        (rsp_is_new),
      .rsp_store_full    (rsp_store_full)
   );

   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (job_valid && full) |-> 1'b0) else $error("job dropped");
   // A result never claims both a new entry and a full store.
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_is_new && rsp_store_full)) else $error("flags clash");
   // A full-store result carries index zero.
   a_full_index: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_store_full) |-> rsp_pattern_index == '0)
      else $error("full result with index");
endmodule
`default_nettype wire

FILE: hdl/mpd_front.sv
// ----------------------------------------------------------------------------
// mpd_front: pattern assembly
// Collects bytes and masks into one pattern and hands it on as a job.
// ----------------------------------------------------------------------------
`default_nettype none
module mpd_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic [7:0]                   data_byte,
   input  wire logic [7:0]                   mask_byte,
   input  wire logic                         mask_match,
   input  wire logic                         normalize,
   input  wire logic [mpd_pkg::LenWidth-1:0] length,
   input  wire logic                         restart,
   output mpd_pkg::job_type                  job,
   output logic                              job_valid
);
   logic [mpd_pkg::RowWidth-1:0] bytes_ff, bytes_in, masks_ff, masks_in, lmask;
   logic [mpd_pkg::LenWidth:0]   pos_ff, pos_in;
   logic [mpd_pkg::LenWidth:0]   len;
   logic [7:0]                   d;
   logic [mpd_pkg::PosWidth-1:0] slot;

   always_comb begin
      if (length == '0) len = 6'd1;
      else if ({1'b0, length} > 6'(mpd_pkg::MaxPatternBytes))
         len = 6'(mpd_pkg::MaxPatternBytes);
      else len = {1'b0, length};
      d = normalize ? (data_byte & mask_byte) : data_byte;
      slot = (pos_ff >= len) ? '0 : pos_ff[mpd_pkg::PosWidth-1:0];
      bytes_in = bytes_ff;
      masks_in = masks_ff;
      bytes_in[8*slot +: 8] = d;
      masks_in[8*slot +: 8] = mask_byte;
      for (int i = 0; i < mpd_pkg::MaxPatternBytes; i++)
         lmask[8*i +: 8] = (6'(i) < len) ? 8'hFF : 8'h00;
      pos_in = pos_ff;
      job_valid = 1'b0;
      if (restart) pos_in = '0;
      else if (in_valid) begin
         if (6'(slot) + 6'd1 >= len) begin
            pos_in = '0;
            job_valid = 1'b1;
         end else pos_in = 6'(slot) + 6'd1;
      end
      job.bytes = bytes_in & lmask;
      job.masks = masks_in;
      job.len_mask = lmask;
      job.mask_match = mask_match;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else pos_ff <= pos_in;
      if (in_valid) begin
         bytes_ff <= bytes_in;
         masks_ff <= masks_in;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/mpd_queue.sv
// ----------------------------------------------------------------------------
// mpd_queue: job queue
// Short FIFO of completed patterns between assembly and search.
// ----------------------------------------------------------------------------
`default_nettype none
module mpd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mpd_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output mpd_pkg::job_type      head,
   output logic                  empty
);
   localparam int AW = $clog2(mpd_pkg::QueueDepth);
   mpd_pkg::job_type slots_ff [mpd_pkg::QueueDepth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign full  = cnt_ff == (AW+1)'(mpd_pkg::QueueDepth);
   assign empty = cnt_ff == '0;
   assign head  = slots_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
      if (push) slots_ff[wp_ff] <= push_job;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(mpd_pkg::QueueDepth)) else $error("count range");
endmodule
`default_nettype wire

FILE: hdl/mpd_back.sv
// ----------------------------------------------------------------------------
// mpd_back: store search
// Scans the unique store for exact and, if mask_match is set, masked matches,
// then appends or reports, and holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module mpd_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mpd_pkg::job_type               job,
   input  wire logic                           job_empty,
   output logic                                job_pop,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [mpd_pkg::IndexWidth-1:0]      rsp_pattern_index,
   output logic                                rsp_is_new,
   output logic                                rsp_store_full
);
   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXACT = 5'b00010,
      S_MASK  = 5'b00100,
      S_DONE  = 5'b01000,
      S_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [mpd_pkg::RowWidth-1:0]   store [mpd_pkg::TableDepth];
   logic [mpd_pkg::RowWidth-1:0]   rd_ff;
   logic [mpd_pkg::CountWidth-1:0] count_ff, count_in;
   logic [mpd_pkg::CountWidth-1:0] addr_ff, addr_in;  // address being read
   logic [mpd_pkg::CountWidth-1:0] cmp_ff, cmp_in;    // entry in rd_ff
   logic                           rdv_ff, rdv_in;
   logic [mpd_pkg::IndexWidth-1:0] idx_ff, idx_in;
   logic                           new_ff, new_in, full_ff, full_in;
   logic                           wr;
   logic                           hit;

   always_comb begin
      if (state_ff == S_EXACT) hit = ((rd_ff ^ job.bytes) & job.len_mask) == '0;
      else hit = (((rd_ff ^ job.bytes) & job.masks) & job.len_mask) == '0;
   end

   always_comb begin
      state_in = state_ff;
      addr_in = addr_ff; cmp_in = addr_ff; rdv_in = 1'b0;
      count_in = count_ff;
      idx_in = idx_ff; new_in = new_ff; full_in = full_ff;
      job_pop = 1'b0; wr = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            addr_in = '0;
            if (!job_empty) state_in = S_EXACT;
         end
         S_EXACT, S_MASK: begin
            if (rdv_ff && hit) begin
               idx_in = mpd_pkg::IndexWidth'(cmp_ff);
               new_in = 1'b0; full_in = 1'b0;
               job_pop = 1'b1;
               state_in = S_OUT;
            end else if (addr_ff < count_ff) begin
               rdv_in = 1'b1;
               addr_in = addr_ff + 1'b1;
            end else if (!rdv_ff) begin
               addr_in = '0;
               if (state_ff == S_EXACT && job.mask_match) state_in = S_MASK;
               else state_in = S_DONE;
            end
         end
         S_DONE: begin
            job_pop = 1'b1;
            state_in = S_OUT;
            if (count_ff >= mpd_pkg::CountWidth'(mpd_pkg::TableDepth)) begin
               idx_in = '0; new_in = 1'b0; full_in = 1'b1;
            end else begin
               wr = 1'b1;
               idx_in = mpd_pkg::IndexWidth'(count_ff);
               new_in = 1'b1; full_in = 1'b0;
               count_in = count_ff + 1'b1;
            end
         end
         S_OUT: if (rsp_pop) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff <= rdv_in;
      end
      addr_ff <= addr_in;
      cmp_ff <= cmp_in;
      idx_ff <= idx_in; new_ff <= new_in; full_ff <= full_in;
   end

   always_ff @(posedge clock) begin
      if (wr) store[count_ff[mpd_pkg::EntryWidth-1:0]] <= job.bytes;
      rd_ff <= store[addr_ff[mpd_pkg::EntryWidth-1:0]];
   end

   assign rsp_empty = state_ff != S_OUT;
   assign rsp_pattern_index = idx_ff;
   assign rsp_is_new = new_ff;
   assign rsp_store_full = full_ff;

   a_flags: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(new_ff && full_ff)) else $error("new and full together");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mpd_pkg::CountWidth'(mpd_pkg::TableDepth)) else $error("count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(idx_ff)))
      else $error("result lost");
endmodule
`default_nettype wire
